// ===== sv/cawf_pkg.sv =====
package cawf_pkg;

  // Flag positions within the packed four-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [7:0] DAA_LIMIT  = 8'h99;
  localparam logic [7:0] DAA_CORR_H = 8'h06;
  localparam logic [7:0] DAA_CORR_C = 8'h60;
  localparam logic [3:0] NIB_MAX    = 4'h9;

  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned M_TDATA_W = 24;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_DAA   = 5'd10,
    OP_CPL   = 5'd11,
    OP_SCF   = 5'd12,
    OP_CCF   = 5'd13,
    OP_RLCA  = 5'd14,
    OP_RRCA  = 5'd15,
    OP_RLA   = 5'd16,
    OP_RRA   = 5'd17,
    OP_RLC   = 5'd18,
    OP_RRC   = 5'd19,
    OP_RL    = 5'd20,
    OP_RR    = 5'd21,
    OP_SLA   = 5'd22,
    OP_SRA   = 5'd23,
    OP_SWAP  = 5'd24,
    OP_SRL   = 5'd25,
    OP_BIT   = 5'd26,
    OP_RES   = 5'd27,
    OP_SET   = 5'd28,
    OP_ADD16 = 5'd29,
    OP_ADDSP = 5'd30,
    OP_LDHLSP = 5'd31
  } op_t;

  typedef enum logic [2:0] {
    SH_RLC  = 3'd0,
    SH_RRC  = 3'd1,
    SH_RL   = 3'd2,
    SH_RR   = 3'd3,
    SH_SLA  = 3'd4,
    SH_SRA  = 3'd5,
    SH_SWAP = 3'd6,
    SH_SRL  = 3'd7
  } shift_t;

  // Offsets that map the two rotate groups onto one shift kind
  localparam logic [2:0] SH_BASE_ACC = 3'd6;
  localparam logic [2:0] SH_BASE_CB  = 3'd2;

  typedef struct packed {
    op_t         op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } req_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
  } res_t;

endpackage

// ===== sv/cawf_core.sv =====
module cawf_core
  import cawf_pkg::*;
(
  input  req_t req,
  output res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;
  logic        cin;
  logic        t;
  logic [8:0]  sum9;
  logic [4:0]  hsum5;
  logic [8:0]  dif9;
  logic [4:0]  hdif5;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  corr;
  logic        daa_c;
  logic [7:0]  daa8;
  shift_t      kind;
  logic [7:0]  sh8;
  logic        sh_c;
  logic [7:0]  mask;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [15:0] ext;
  logic [15:0] sp16;
  logic [4:0]  sp_h5;
  logic [8:0]  sp_c9;

  assign a   = req.operand_a[7:0];
  assign b   = req.operand_b[7:0];
  assign f   = req.flags_in;
  assign cin = f[FLAG_C];
  assign t   = ((req.op == OP_ADC) || (req.op == OP_SBC)) ? cin : 1'b0;

  assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, t};
  assign hsum5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
  assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, t};
  assign hdif5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
  assign inc8  = a + 8'd1;
  assign dec8  = a - 8'd1;

  // Decimal adjust: subtract mode uses only the stored H and C
  always_comb begin
    corr  = 8'd0;
    daa_c = cin;
    if (f[FLAG_N]) begin
      if (f[FLAG_H]) corr = corr | DAA_CORR_H;
      if (cin) corr = corr | DAA_CORR_C;
      daa8 = a - corr;
    end else begin
      if (f[FLAG_H] || (a[3:0] > NIB_MAX)) corr = corr | DAA_CORR_H;
      if (cin || (a > DAA_LIMIT)) begin
        corr  = corr | DAA_CORR_C;
        daa_c = 1'b1;
      end
      daa8 = a + corr;
    end
  end

  assign kind = shift_t'(req.op[2:0] - ((req.op <= OP_RRA) ? SH_BASE_ACC : SH_BASE_CB));

  always_comb begin
    unique case (kind)
      SH_RLC:  begin sh_c = a[7]; sh8 = {a[6:0], a[7]};     end
      SH_RRC:  begin sh_c = a[0]; sh8 = {a[0], a[7:1]};     end
      SH_RL:   begin sh_c = a[7]; sh8 = {a[6:0], cin};      end
      SH_RR:   begin sh_c = a[0]; sh8 = {cin, a[7:1]};      end
      SH_SLA:  begin sh_c = a[7]; sh8 = {a[6:0], 1'b0};     end
      SH_SRA:  begin sh_c = a[0]; sh8 = {a[7], a[7:1]};     end
      SH_SWAP: begin sh_c = 1'b0; sh8 = {a[3:0], a[7:4]};   end
      SH_SRL:  begin sh_c = a[0]; sh8 = {1'b0, a[7:1]};     end
    endcase
  end

  assign mask   = 8'd1 << req.bit_index;
  assign sum17  = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign hsum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
  assign ext    = {{8{b[7]}}, b};
  assign sp16   = req.operand_a + ext;
  assign sp_h5  = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_c9  = {1'b0, req.operand_a[7:0]} + {1'b0, b};

  always_comb begin
    res.result    = 16'd0;
    res.flags_out = f;
    unique case (req.op)
      OP_ADD, OP_ADC: begin
        res.result    = {8'd0, sum9[7:0]};
        res.flags_out = {sum9[7:0] == 8'd0, 1'b0, hsum5[4], sum9[8]};
      end
      OP_SUB, OP_SBC: begin
        res.result    = {8'd0, dif9[7:0]};
        res.flags_out = {dif9[7:0] == 8'd0, 1'b1, hdif5[4], dif9[8]};
      end
      OP_CP: begin
        res.result    = req.operand_a;
        res.flags_out = {dif9[7:0] == 8'd0, 1'b1, hdif5[4], dif9[8]};
      end
      OP_AND: begin
        res.result    = {8'd0, a & b};
        res.flags_out = {(a & b) == 8'd0, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        res.result    = {8'd0, a ^ b};
        res.flags_out = {(a ^ b) == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      OP_OR: begin
        res.result    = {8'd0, a | b};
        res.flags_out = {(a | b) == 8'd0, 1'b0, 1'b0, 1'b0};
      end
      OP_INC: begin
        res.result    = {8'd0, inc8};
        res.flags_out = {inc8 == 8'd0, 1'b0, inc8[3:0] == 4'h0, cin};
      end
      OP_DEC: begin
        res.result    = {8'd0, dec8};
        res.flags_out = {dec8 == 8'd0, 1'b1, dec8[3:0] == 4'hF, cin};
      end
      OP_DAA: begin
        res.result    = {8'd0, daa8};
        res.flags_out = {daa8 == 8'd0, f[FLAG_N], 1'b0, daa_c};
      end
      OP_CPL: begin
        res.result    = {8'd0, ~a};
        res.flags_out = {f[FLAG_Z], 1'b1, 1'b1, cin};
      end
      OP_SCF: begin
        res.result    = req.operand_a;
        res.flags_out = {f[FLAG_Z], 1'b0, 1'b0, 1'b1};
      end
      OP_CCF: begin
        res.result    = req.operand_a;
        res.flags_out = {f[FLAG_Z], 1'b0, 1'b0, ~cin};
      end
      // accumulator rotates always clear Z
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        res.result    = {8'd0, sh8};
        res.flags_out = {1'b0, 1'b0, 1'b0, sh_c};
      end
      OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        res.result    = {8'd0, sh8};
        res.flags_out = {sh8 == 8'd0, 1'b0, 1'b0, sh_c};
      end
      OP_BIT: begin
        res.result    = req.operand_a;
        res.flags_out = {(a & mask) == 8'd0, 1'b0, 1'b1, cin};
      end
      OP_RES: begin
        res.result    = {8'd0, a & ~mask};
      end
      OP_SET: begin
        res.result    = {8'd0, a | mask};
      end
      OP_ADD16: begin
        res.result    = sum17[15:0];
        res.flags_out = {f[FLAG_Z], 1'b0, hsum13[12], sum17[16]};
      end
      OP_ADDSP, OP_LDHLSP: begin
        res.result    = sp16;
        res.flags_out = {1'b0, 1'b0, sp_h5[4], sp_c9[8]};
      end
    endcase
  end

endmodule

// ===== sv/cpu_alu_with_flags.sv =====
// 8-bit ALU with Z/N/H/C flags, two register stages.
//
// Input channel (s_*): one beat carries an operation code in s_tuser and the
// operands, bit number and current flags in s_tdata. Output channel (m_*):
// one beat per input beat carrying the result word and the merged flags.
// Flags an operation does not define keep the value given in flags_in.
//
// An accepted input beat passes from the input register once through the ALU
// into the result register shown on m_tvalid. Throughput: one beat per cycle
// while the receiver is ready, set by the single pass through the ALU between
// the input register and the result register; there is no iterating unit.
//
// Reset (rst, synchronous, active high) empties both stages; no result is
// shown after reset until a new beat arrives.
//
// When the receiver stalls, the result register holds its beat and the input
// register fills behind it; s_tready drops only once both stages are full,
// and it returns in the same cycle that the receiver takes a beat.
module cpu_alu_with_flags
  import cawf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata, lowest bit up: operand_a[15:0], operand_b[15:0],
  // bit_index[2:0], flags_in[3:0], zero pad[0]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: req_type[4:0]
  input  logic [4:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata, lowest bit up: result[15:0], flags_out[3:0], zero pad[3:0]
  output logic [M_TDATA_W-1:0] m_tdata
);

  logic in_valid;
  req_t in_req;
  logic out_valid;
  res_t out_res;
  res_t alu_res;
  logic in_adv;
  logic in_load;

  // The result register moves on when empty or when its beat is taken
  assign in_adv   = !out_valid || m_tready;
  assign s_tready = !in_valid || in_adv;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the request fields on every accepted beat
  always_ff @(posedge clk) begin
    if (in_load) begin
      in_req.op        <= op_t'(s_tuser);
      in_req.operand_a <= s_tdata[15:0];
      in_req.operand_b <= s_tdata[31:16];
      in_req.bit_index <= s_tdata[34:32];
      in_req.flags_in  <= s_tdata[38:35];
    end
  end

  cawf_core u_core (
    .req (in_req),
    .res (alu_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_adv) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result while the receiver stalls; otherwise load any waiting beat
  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      out_res <= alu_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_res.flags_out, out_res.result};

endmodule

// ===== sv/cawf_chk.sv =====
module cawf_chk
  import cawf_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [4:0]           s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Reset empties the result stage
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat shown after reset");

  // A stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // A waiting input beat holds until it is taken
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("waiting input beat changed");

  // A ready receiver never back-pressures the input side
  assert property (@(posedge clk) disable iff (rst) m_tready |-> s_tready)
    else $error("input stalled while receiver ready");

  // A fresh result only appears for an input beat that passed through both stages
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result beat without matching input beat");

endmodule

bind cpu_alu_with_flags cawf_chk u_chk (.*);

// ===== tb/alu_flag_checker.sv =====
module alu_flag_checker
  import cawf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,
  input  logic [4:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  output int          mismatches,
  output int          in_flight,
  output int          checked
);

  typedef struct {
    op_t  op;
    res_t res;
  } alu_expect_t;

  alu_expect_t pending_results[$];

  // Work out result word and merged flags for one operation
  function automatic res_t alu_predict(req_t rq);
    logic [7:0]  a, b, r8, corr;
    logic [15:0] r16, ext;
    logic [3:0]  f, nf;
    logic [8:0]  s9;
    logic [4:0]  s5, k5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic        t, byte_op;
    shift_t      kind;
    res_t        out;
    a = rq.operand_a[7:0];
    b = rq.operand_b[7:0];
    f = rq.flags_in;
    nf = f;
    r8 = '0;
    r16 = '0;
    t = 1'b0;
    byte_op = 1'b1;
    case (rq.op)
      OP_ADD, OP_ADC: begin
        t = (rq.op == OP_ADC) & f[FLAG_C];
        s9 = {1'b0, a} + {1'b0, b} + {8'b0, t};
        s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'b0, t};
        r8 = s9[7:0];
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = s5[4];
        nf[FLAG_C] = s9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        t = (rq.op == OP_SBC) & f[FLAG_C];
        s9 = {1'b0, a} - {1'b0, b} - {8'b0, t};
        s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'b0, t};
        r8 = s9[7:0];
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = s5[4];
        nf[FLAG_C] = s9[8];
        if (rq.op == OP_CP) begin
          byte_op = 1'b0;
          r16 = rq.operand_a;
        end
      end
      OP_AND, OP_XOR, OP_OR: begin
        case (rq.op)
          OP_AND:  r8 = a & b;
          OP_XOR:  r8 = a ^ b;
          default: r8 = a | b;
        endcase
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = (rq.op == OP_AND);
        nf[FLAG_C] = 1'b0;
      end
      OP_INC: begin
        r8 = a + 8'h01;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = (r8[3:0] == 4'h0);
      end
      OP_DEC: begin
        r8 = a - 8'h01;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = (r8[3:0] == 4'hF);
      end
      OP_DAA: begin
        corr = '0;
        if (f[FLAG_N]) begin
          if (f[FLAG_H]) corr = corr | DAA_CORR_H;
          if (f[FLAG_C]) corr = corr | DAA_CORR_C;
          r8 = a - corr;
        end else begin
          if (f[FLAG_H] || a[3:0] > NIB_MAX) corr = corr | DAA_CORR_H;
          if (f[FLAG_C] || a > DAA_LIMIT) begin
            corr = corr | DAA_CORR_C;
            nf[FLAG_C] = 1'b1;
          end
          r8 = a + corr;
        end
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_H] = 1'b0;
      end
      OP_CPL: begin
        r8 = ~a;
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = 1'b1;
      end
      OP_SCF, OP_CCF: begin
        byte_op = 1'b0;
        r16 = rq.operand_a;
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = 1'b0;
        nf[FLAG_C] = (rq.op == OP_SCF) ? 1'b1 : ~f[FLAG_C];
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA, OP_RLC, OP_RRC,
      OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL: begin
        k5 = 5'((rq.op <= OP_RRA) ? (rq.op - OP_RLCA) : (rq.op - OP_RLC));
        kind = shift_t'(k5[2:0]);
        case (kind)
          SH_RLC:  begin t = a[7]; r8 = {a[6:0], a[7]};       end
          SH_RRC:  begin t = a[0]; r8 = {a[0], a[7:1]};       end
          SH_RL:   begin t = a[7]; r8 = {a[6:0], f[FLAG_C]};  end
          SH_RR:   begin t = a[0]; r8 = {f[FLAG_C], a[7:1]};  end
          SH_SLA:  begin t = a[7]; r8 = {a[6:0], 1'b0};       end
          SH_SRA:  begin t = a[0]; r8 = {a[7], a[7:1]};       end
          SH_SWAP: begin t = 1'b0; r8 = {a[3:0], a[7:4]};     end
          default: begin t = a[0]; r8 = {1'b0, a[7:1]};       end
        endcase
        // accumulator forms always clear Z
        nf[FLAG_Z] = (rq.op >= OP_RLC) && (r8 == 8'h00);
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = 1'b0;
        nf[FLAG_C] = t;
      end
      OP_BIT: begin
        byte_op = 1'b0;
        r16 = rq.operand_a;
        nf[FLAG_Z] = ~a[rq.bit_index];
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = 1'b1;
      end
      OP_RES: r8 = a & ~(8'h01 << rq.bit_index);
      OP_SET: r8 = a | (8'h01 << rq.bit_index);
      OP_ADD16: begin
        byte_op = 1'b0;
        s17 = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
        s13 = {1'b0, rq.operand_a[11:0]} + {1'b0, rq.operand_b[11:0]};
        r16 = s17[15:0];
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = s13[12];
        nf[FLAG_C] = s17[16];
      end
      OP_ADDSP, OP_LDHLSP: begin
        byte_op = 1'b0;
        ext = {{8{b[7]}}, b};
        r16 = rq.operand_a + ext;
        s5 = {1'b0, rq.operand_a[3:0]} + {1'b0, b[3:0]};
        s9 = {1'b0, rq.operand_a[7:0]} + {1'b0, b};
        nf[FLAG_Z] = 1'b0;
        nf[FLAG_N] = 1'b0;
        nf[FLAG_H] = s5[4];
        nf[FLAG_C] = s9[8];
      end
      default: ;
    endcase
    if (byte_op) r16 = {8'h00, r8};
    out.result = r16;
    out.flags_out = nf;
    return out;
  endfunction

  initial begin
    mismatches = 0;
    in_flight = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    req_t        rq;
    alu_expect_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with none expected: actual %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (m_tdata[15:0] !== want.res.result) begin
            $display("%0t: %s result: expected %h, actual %h", $time, want.op.name(),
                     want.res.result, m_tdata[15:0]);
            mismatches++;
          end
          if (m_tdata[19:16] !== want.res.flags_out) begin
            $display("%0t: %s flags: expected %b, actual %b", $time, want.op.name(),
                     want.res.flags_out, m_tdata[19:16]);
            mismatches++;
          end
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        rq.op = op_t'(s_tuser);
        rq.operand_a = s_tdata[15:0];
        rq.operand_b = s_tdata[31:16];
        rq.bit_index = s_tdata[34:32];
        rq.flags_in = s_tdata[38:35];
        want.op = rq.op;
        want.res = alu_predict(rq);
        pending_results.push_back(want);
      end
      in_flight = pending_results.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the flag ALU. A directed pass walks every
// operation code through its corner cases, then random operations run in
// four phases that vary input gaps and output back-pressure. The checker
// beside the block predicts every result beat and counts mismatches.
module tb_top
  import cawf_pkg::*;
();

  // Cycles with no beat on either side before the run is declared hung;
  // far beyond the longest gap or stall plus the two-stage latency.
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_OPS  = 255;
  localparam int DRAIN_WAIT = 16;

  localparam logic [3:0] F_Z = 4'(1 << FLAG_Z);
  localparam logic [3:0] F_N = 4'(1 << FLAG_N);
  localparam logic [3:0] F_H = 4'(1 << FLAG_H);
  localparam logic [3:0] F_C = 4'(1 << FLAG_C);

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic [4:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;

  // Set to run a side without any idling
  bit quiet_in;
  bit quiet_out;
  int sent;
  int mismatches;
  int in_flight;
  int checked;

  cpu_alu_with_flags u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  alu_flag_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .in_flight  (in_flight),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one
  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Bias bytes towards the values where carries and DAA corrections flip
  function automatic logic [7:0] pick_byte();
    logic [7:0] corners[10];
    corners = '{8'h00, 8'hFF, 8'h0F, 8'h10, 8'h7F, 8'h80, 8'h99, 8'h9A, 8'h09, 8'h01};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 9)];
    return 8'($urandom);
  endfunction

  function automatic logic [15:0] pick_word();
    logic [7:0] hi;
    hi = ($urandom_range(0, 1) == 0) ? pick_byte() : 8'($urandom);
    return {hi, pick_byte()};
  endfunction

  // Present one beat at the falling edge, hold it until the block takes it
  task automatic issue_op(op_t op, logic [15:0] a, logic [15:0] b, logic [2:0] idx,
                          logic [3:0] f);
    int gap;
    gap = pick_gap(quiet_in);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {1'b0, f, idx, b, a};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic random_ops(int count);
    repeat (count) begin
      issue_op(op_t'($urandom_range(0, 31)), pick_word(), pick_word(),
               3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
    end
  endtask

  // Receiver: stall for a random spell, then stay ready for a run of cycles
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = pick_gap(quiet_out);
      if (stall > 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("%0t: no beat moved for %0d cycles, %0d results outstanding", $time,
             IDLE_LIMIT, in_flight);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_ADD;
    rst = 1'b1;
    sent = 0;
    quiet_in = 1'b0;
    quiet_out = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed pass: each operation at least once, at the edges that matter for it
    issue_op(OP_ADD,    16'h12FF, 16'hAB01, 3'd0, 4'h0);      // zero, half and full carry
    issue_op(OP_ADC,    16'h000F, 16'h0000, 3'd0, F_C);       // carry-in makes the half carry
    issue_op(OP_SUB,    16'h0000, 16'h0001, 3'd0, F_Z);       // borrow through both nibbles
    issue_op(OP_SBC,    16'hFF10, 16'h000F, 3'd0, F_C);       // difference is zero with a half borrow
    issue_op(OP_SBC,    16'h0000, 16'h00FF, 3'd0, F_C);       // wraps to zero with borrow out
    issue_op(OP_AND,    16'h00F0, 16'h000F, 3'd0, 4'hF);
    issue_op(OP_XOR,    16'hFFFF, 16'hFFFF, 3'd0, 4'h0);
    issue_op(OP_OR,     16'h0000, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_CP,     16'hABCD, 16'h00CD, 3'd0, 4'h0);      // operand comes back whole
    issue_op(OP_INC,    16'h00FF, 16'h0000, 3'd0, F_C);       // carry kept
    issue_op(OP_DEC,    16'h0010, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_DAA,    16'h009A, 16'h0000, 3'd0, 4'h0);      // add mode, both corrections
    issue_op(OP_DAA,    16'h0000, 16'h0000, 3'd0, F_N | F_H | F_C); // subtract mode
    issue_op(OP_CPL,    16'h005A, 16'h0000, 3'd0, F_Z | F_C);
    issue_op(OP_SCF,    16'hFFFF, 16'h0000, 3'd0, F_Z | F_N | F_H);
    issue_op(OP_CCF,    16'h8001, 16'h0000, 3'd0, F_C);
    issue_op(OP_RLCA,   16'h0080, 16'h0000, 3'd0, F_Z);
    issue_op(OP_RRCA,   16'h0001, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_RLA,    16'h0080, 16'h0000, 3'd0, 4'h0);      // result zero, Z still clear
    issue_op(OP_RRA,    16'h0000, 16'h0000, 3'd0, F_C);
    issue_op(OP_RLC,    16'h0000, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_RRC,    16'h00FE, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_RL,     16'h0080, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_RR,     16'h0001, 16'h0000, 3'd0, F_C);
    issue_op(OP_SLA,    16'h0080, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_SRA,    16'h0081, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_SWAP,   16'h00F0, 16'h0000, 3'd0, F_C);
    issue_op(OP_SRL,    16'h0001, 16'h0000, 3'd0, 4'h0);
    issue_op(OP_BIT,    16'hFF7F, 16'h0000, 3'd7, F_C);
    issue_op(OP_RES,    16'h00FF, 16'h0000, 3'd0, 4'hF);
    issue_op(OP_SET,    16'hFF00, 16'h0000, 3'd7, 4'h0);
    issue_op(OP_ADD16,  16'h0FFF, 16'hF001, 3'd0, F_Z);       // carries out of bits 11 and 15
    issue_op(OP_ADDSP,  16'hFFF8, 16'h00FF, 3'd0, F_Z | F_N); // offset of minus one
    issue_op(OP_LDHLSP, 16'h0000, 16'hFF80, 3'd0, 4'hF);      // most negative offset

    // Random phases: gaps on both sides, then unbroken streams, then
    // back-pressure alone, then sender gaps alone
    random_ops(PHASE_OPS);
    quiet_in = 1'b1;
    quiet_out = 1'b1;
    random_ops(PHASE_OPS);
    quiet_out = 1'b0;
    random_ops(PHASE_OPS);
    quiet_in = 1'b0;
    quiet_out = 1'b1;
    random_ops(PHASE_OPS);

    @(negedge clk);
    s_tvalid = 1'b0;
    wait (in_flight == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d operations over all 32 codes: directed corner cases, then random",
             sent);
    $display("operands and flags under varied gaps and stalls; %0d results compared.",
             checked);
    if (mismatches == 0 && in_flight == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cawf_pkg.sv
sv/cawf_core.sv
sv/cpu_alu_with_flags.sv
sv/cawf_chk.sv
tb/alu_flag_checker.sv
tb/tb_top.sv
